// File: rtl/ezr_pkg.sv
// Package for the ZYX Euler angle to rotation matrix block: default parameter values,
// output width and the constant function that builds the quarter-wave sine table.
// Used by ezr_front, ezr_back and the top level; depends on nothing else.
`timescale 1ns / 1ps
package ezr_pkg;

  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int QUARTER_DEPTH_DEF = 256;
  localparam int OUT_WIDTH         = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  // Entry k of the quarter-wave table: Q30 Taylor series of sin to x^13 in Horner form,
  // then rounded to fb fraction bits and capped at one. Evaluated at elaboration only.
  function automatic logic [63:0] sine_entry(input int k, input int log2d, input int fb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] unity;
    x = (Q30_HALF_PI * 64'(k) + (64'd1 << (log2d - 1))) >> log2d;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    e = (s + (64'd1 << (29 - fb))) >> (30 - fb);
    unity = 64'd1 << fb;
    if (e > unity || k == (1 << log2d)) begin
      e = unity;
    end
    return e;
  endfunction

endpackage

// File: rtl/ezr_front.sv
// Front end: takes an attitude transaction, maps each angle to a table index and looks up
// the six sines and cosines into a register. Depends on ezr_pkg.
`timescale 1ns / 1ps
module ezr_front #(
  parameter int ANGLE_WIDTH   = ezr_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS     = ezr_pkg::FRAC_BITS_DEF,
  parameter int QUARTER_DEPTH = ezr_pkg::QUARTER_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3*ANGLE_WIDTH-1:0]     in_angles,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [6*(FRAC_BITS+2)-1:0]   out_trig
);
  import ezr_pkg::*;

  localparam int LD = $clog2(QUARTER_DEPTH);
  localparam int IB = LD + 2;
  localparam int VW = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 1;

  logic [TW-1:0] tab [QUARTER_DEPTH+1];
  logic [IB-1:0] idx [6];
  logic signed [VW-1:0] val [6];
  logic [6*VW-1:0] trig;
  logic valid;

  for (genvar k = 0; k <= QUARTER_DEPTH; k++) begin : g_tab
    assign tab[k] = TW'(sine_entry(k, LD, FRAC_BITS));
  end

  // Even slots are sines, odd slots cosines (a quarter turn ahead).
  for (genvar a = 0; a < 3; a++) begin : g_angle
    if (ANGLE_WIDTH >= IB) begin : g_wide
      assign idx[2*a] = in_angles[a*ANGLE_WIDTH+ANGLE_WIDTH-1 -: IB];
    end else begin : g_narrow
      assign idx[2*a] = {in_angles[a*ANGLE_WIDTH +: ANGLE_WIDTH], (IB-ANGLE_WIDTH)'(0)};
    end
    assign idx[2*a+1] = idx[2*a] + IB'(QUARTER_DEPTH);
  end

  for (genvar j = 0; j < 6; j++) begin : g_look
    logic [1:0]    quad;
    logic [LD:0]   addr;
    logic [VW-1:0] mag;
    assign quad = idx[j][IB-1:IB-2];
    assign addr = quad[0] ? ((LD+1)'(QUARTER_DEPTH) - {1'b0, idx[j][LD-1:0]})
                          : {1'b0, idx[j][LD-1:0]};
    assign mag    = VW'(tab[addr]);
    assign val[j] = quad[1] ? -$signed(mag) : $signed(mag);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_trig  = trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      for (int j = 0; j < 6; j++) begin
        trig[j*VW +: VW] <= val[j];
      end
    end
  end

endmodule

// File: rtl/ezr_queue.sv
// Short register queue between the front end and the multiply pipeline.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps
module ezr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             can_push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign can_push  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> can_push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not follow a lone write");
`endif

endmodule

// File: rtl/ezr_back.sv
// Back end: two rounded multiply stages, then the sums, saturation and the output
// register. Depends on ezr_pkg for the output width.
`timescale 1ns / 1ps
module ezr_back #(
  parameter int FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_pop,
  input  logic [6*(FRAC_BITS+2)-1:0]       in_trig,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [9*ezr_pkg::OUT_WIDTH-1:0]  out_matrix
);
  import ezr_pkg::*;

  localparam int VW = FRAC_BITS + 2;
  localparam int SW = VW + 1;
  localparam logic signed [2*VW-1:0] HALF  = (2*VW)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]   UNITY = SW'(1) << FRAC_BITS;

  function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = a * b + HALF;
    return VW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > UNITY) begin
      c = UNITY;
    end else if (v < -UNITY) begin
      c = -UNITY;
    end
    return OUT_WIDTH'(c);
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [VW-1:0] v);
    return SW'(v);
  endfunction

  logic signed [VW-1:0] sr, cr, sp, cp, sy, cy;
  logic advance;

  // Stage one: first-level products.
  logic s1_v;
  logic signed [VW-1:0] p_cycp, p_cysp, p_crsy, p_sysr, p_cycr, p_cpsy, p_ncysr, p_cpsr;
  logic signed [VW-1:0] p_cpcr, p_sr, p_sp;
  // Stage two: second-level products, first-level terms carried along.
  logic s2_v;
  logic signed [VW-1:0] q_cycp, q_crsy, q_sysr, q_cycr, q_cpsy, q_ncysr, q_cpsr, q_cpcr;
  logic signed [VW-1:0] q_sp, q_a01, q_a02, q_a11, q_a12;
  logic m_v;
  logic [9*OUT_WIDTH-1:0] m_data;

  assign sr = $signed(in_trig[0*VW +: VW]);
  assign cr = $signed(in_trig[1*VW +: VW]);
  assign sp = $signed(in_trig[2*VW +: VW]);
  assign cp = $signed(in_trig[3*VW +: VW]);
  assign sy = $signed(in_trig[4*VW +: VW]);
  assign cy = $signed(in_trig[5*VW +: VW]);

  assign advance    = !m_v || out_ready;
  assign in_pop     = advance && in_valid;
  assign out_valid  = m_v;
  assign out_matrix = m_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      m_v  <= 1'b0;
    end else if (advance) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      m_v  <= s2_v;
    end
    if (advance) begin
      p_cycp  <= fmul(cy, cp);
      p_cysp  <= fmul(cy, sp);
      p_crsy  <= fmul(cr, sy);
      p_sysr  <= fmul(sy, sr);
      p_cycr  <= fmul(cy, cr);
      p_cpsy  <= fmul(cp, sy);
      p_ncysr <= fmul(-cy, sr);
      p_cpsr  <= fmul(cp, sr);
      p_cpcr  <= fmul(cp, cr);
      p_sr    <= sr;
      p_sp    <= sp;

      q_a01   <= fmul(p_cysp, p_sr);
      q_a02   <= fmul(p_cycr, p_sp);
      q_a11   <= fmul(p_sysr, p_sp);
      q_a12   <= fmul(p_crsy, p_sp);
      q_cycp  <= p_cycp;
      q_crsy  <= p_crsy;
      q_sysr  <= p_sysr;
      q_cycr  <= p_cycr;
      q_cpsy  <= p_cpsy;
      q_ncysr <= p_ncysr;
      q_cpsr  <= p_cpsr;
      q_cpcr  <= p_cpcr;
      q_sp    <= p_sp;

      m_data[0*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_cycp));
      m_data[1*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_a01) - ext(q_crsy));
      m_data[2*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_sysr) + ext(q_a02));
      m_data[3*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_cpsy));
      m_data[4*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_a11) + ext(q_cycr));
      m_data[5*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_ncysr) + ext(q_a12));
      m_data[6*OUT_WIDTH +: OUT_WIDTH] <= sat(-ext(q_sp));
      m_data[7*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_cpsr));
      m_data[8*OUT_WIDTH +: OUT_WIDTH] <= sat(ext(q_cpcr));
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
      (m_v && !out_ready) |=> (m_v && $stable(s1_v) && $stable(s2_v)))
    else $error("pipeline moved while the output was stalled");
  a_pop_only_advancing: assert property (@(posedge clk) disable iff (rst)
      in_pop |=> s1_v)
    else $error("popped transaction did not enter stage one");
  a_stall_holds_data: assert property (@(posedge clk) disable iff (rst)
      (m_v && !out_ready) |=> $stable(m_data))
    else $error("output data changed while the output was stalled");
`endif

endmodule

// File: rtl/euler_zyx_to_rotation_matrix.sv
// Top level of the ZYX Euler angle to rotation matrix converter.
// Instantiates ezr_front, ezr_queue and ezr_back; depends on ezr_pkg.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one attitude per transaction:
//   roll, pitch and yaw as binary angles in which a full turn is 2^ANGLE_WIDTH steps.
//   The master channel (m_tvalid, m_tready, m_tdata) returns one transaction per attitude
//   holding the nine entries of R = Rz(yaw) * Ry(pitch) * Rx(roll) in signed fixed point
//   with FRAC_BITS fraction bits, each saturated to plus or minus one.
//   Throughput is one transaction per cycle while m_tready stays high. The front end
//   registers the table lookups, a two-entry queue decouples it from the multiply
//   pipeline, and the back end has two multiply stages followed by the output register.
//   When m_tready is low the back end holds its stages, the queue absorbs two further
//   attitudes and the front register one more before s_tready falls; nothing is lost
//   or repeated.
//   The sine table is a constant, so reset (rst, synchronous, active high) only empties
//   the front register, the queue and the pipeline; no clearing pass is needed.
`timescale 1ns / 1ps
module euler_zyx_to_rotation_matrix #(
  parameter int ANGLE_WIDTH   = ezr_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS     = ezr_pkg::FRAC_BITS_DEF,
  parameter int QUARTER_DEPTH = ezr_pkg::QUARTER_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // Fields from bit 0: roll_angle, pitch_angle, yaw_angle, zero padding to whole bytes.
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // Fields from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22.
  output logic [9*ezr_pkg::OUT_WIDTH-1:0]       m_tdata
);
  import ezr_pkg::*;

  localparam int VW = FRAC_BITS + 2;
  localparam int TRIG_W = 6 * VW;

  // Front end to queue.
  logic              f_valid;
  logic              f_ready;
  logic [TRIG_W-1:0] f_trig;
  // Queue to back end.
  logic              q_valid;
  logic              q_pop;
  logic [TRIG_W-1:0] q_trig;

  // The padding bits of s_tdata carry nothing and are left unread.
  ezr_front #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .QUARTER_DEPTH (QUARTER_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_angles (s_tdata[3*ANGLE_WIDTH-1:0]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_trig  (f_trig)
  );

  // The queue accepts only while it has room, so the front end never overruns it.
  ezr_queue #(
    .WIDTH (TRIG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && f_ready),
    .can_push  (f_ready),
    .push_data (f_trig),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_trig)
  );

  ezr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_pop     (q_pop),
    .in_trig    (q_trig),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_matrix (m_tdata)
  );

endmodule
